// ----- hw/rtl/page_framebuffer_draw_engine_core_macros.svh -----
// assertion macros for the draw engine
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define PFDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pfde_pkg.sv -----
`default_nettype none

package pfde_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_RECT  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam int PAGE_W = 7;

  typedef logic signed [PAGE_W-1:0] page_t;

  localparam logic [7:0] FULL_MASK = 8'hff;

  // low n bits set, none for n == 0
  function automatic logic [7:0] low_mask(input logic [2:0] n);
    return ~(FULL_MASK << n);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/page_framebuffer_draw_engine_core.sv -----
`default_nettype none

// Monochrome page frame store (byte = 8 vertical pixels, bit 0 on top) with clear, set or
// erase pixel, fill or erase rectangle and read byte. One shared index unit (page * COLUMNS +
// x + column, with the store bound compare) walks the bytes of a pixel or rectangle command,
// one read-modify-write per cycle through a single-port-write store with a registered read
// and one-back forwarding. Each byte is read in the walk state, then modified and written
// from the read register, and the result of the final byte is registered onto out_strobe.
// A rectangle visits max(width, 1) bytes in each page that it covers; every covered byte is
// visited, including those that fall off the store and are skipped. Busy drops in the cycle
// that shows the result, so the next start can be taken there. After reset a clearing pass
// over the whole store runs with busy high. Start is taken while busy is low. Each command
// gives exactly one result, shown for a single cycle with out_strobe; the receiver must take
// it then, as there is no way to hold it off.
`include "page_framebuffer_draw_engine_core_macros.svh"

module page_framebuffer_draw_engine_core #(
  parameter int COLUMNS     = 128,
  parameter int STORE_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_mode,
  input  wire logic signed [8:0] in_pos_x,
  input  wire logic signed [7:0] in_pos_y,
  input  wire logic [7:0]        in_rect_width,
  input  wire logic [6:0]        in_rect_height,
  input  wire logic              in_erase,
  input  wire logic [9:0]        in_read_index,
  output logic                   out_strobe,
  output logic                   out_status,
  output logic [7:0]             out_read_byte
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(COLUMNS);
  localparam int IW = (CW + 8 > AW + 2) ? CW + 8 : AW + 2;
  localparam int RW = AW + 10;

  localparam logic signed [IW-1:0] COLS_S  = IW'(COLUMNS);
  localparam logic signed [IW-1:0] STORE_S = IW'(STORE_BYTES);
  localparam logic [AW-1:0]        LAST_A  = AW'(STORE_BYTES - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_PIX   = 3'd3;
  localparam logic [2:0] S_RECT  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;

  logic [7:0] mem [STORE_BYTES];

  logic [2:0]           st_r, st_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;
  pfde_pkg::page_t      p_r, p_nxt;
  pfde_pkg::page_t      pfirst_r, pfirst_nxt;
  pfde_pkg::page_t      plast_r, plast_nxt;
  logic [7:0]           c_r, c_nxt;
  logic signed [8:0]    x_r, x_nxt;
  logic [7:0]           w_r, w_nxt;
  logic [2:0]           ys_r, ys_nxt;
  logic [2:0]           es_r, es_nxt;
  logic [2:0]           h3_r, h3_nxt;
  logic                 erase_r, erase_nxt;
  logic [9:0]           rd_idx_r, rd_idx_nxt;

  logic signed [8:0]    e_sum;
  logic signed [IW-1:0] idx;
  logic                 in_range;
  logic                 col_end;
  logic [RW-1:0]        rd_wide;
  logic [7:0]           rect_mask;

  logic                 e_valid, e_ok, e_wr, e_rd, e_erase, e_last, e_status;
  logic [AW-1:0]        e_addr;
  logic [7:0]           e_mask;

  logic                 r_valid_r, r_last_r;
  logic                 r_ok_r, r_wr_r, r_rd_r, r_erase_r, r_status_r;
  logic [AW-1:0]        r_addr_r;
  logic [7:0]           r_mask_r;
  logic [7:0]           rdata_r;

  logic                 lw_valid_r;
  logic [AW-1:0]        lw_addr_r;
  logic [7:0]           lw_data_r;

  logic [7:0]           cur;
  logic [7:0]           w_data;
  logic                 w_en;

  logic                 out_strobe_r, out_status_r;
  logic [7:0]           out_read_byte_r;

  assign busy          = (st_r != S_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_read_byte = out_read_byte_r;

  assign e_sum = in_pos_y + $signed({2'b00, in_rect_height});

  // shared index unit
  assign idx = IW'(p_r) * COLS_S + IW'(x_r) + IW'($signed({1'b0, c_r}));
  assign in_range = (idx >= 0) && (idx < STORE_S);
  assign col_end = (w_r == 8'd0) || (c_r == w_r - 8'd1);
  assign rd_wide = RW'(rd_idx_r);

  always_comb begin
    if (pfirst_r == plast_r) begin
      rect_mask = pfde_pkg::low_mask(h3_r) << ys_r;
    end else if (p_r == pfirst_r) begin
      rect_mask = pfde_pkg::FULL_MASK << ys_r;
    end else if (p_r == plast_r) begin
      rect_mask = pfde_pkg::low_mask(es_r);
    end else begin
      rect_mask = pfde_pkg::FULL_MASK;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    sweep_nxt  = sweep_r;
    p_nxt      = p_r;
    pfirst_nxt = pfirst_r;
    plast_nxt  = plast_r;
    c_nxt      = c_r;
    x_nxt      = x_r;
    w_nxt      = w_r;
    ys_nxt     = ys_r;
    es_nxt     = es_r;
    h3_nxt     = h3_r;
    erase_nxt  = erase_r;
    rd_idx_nxt = rd_idx_r;
    e_valid    = 1'b0;
    e_ok       = 1'b0;
    e_wr       = 1'b0;
    e_rd       = 1'b0;
    e_erase    = erase_r;
    e_last     = 1'b0;
    e_status   = 1'b0;
    e_addr     = idx[AW-1:0];
    e_mask     = rect_mask;
    unique case (st_r) inside
      S_INIT, S_CLEAR: begin
        e_valid   = 1'b1;
        e_ok      = 1'b1;
        e_wr      = 1'b1;
        e_erase   = 1'b1;
        e_mask    = pfde_pkg::FULL_MASK;
        e_addr    = sweep_r;
        e_last    = (st_r == S_CLEAR) && (sweep_r == LAST_A);
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_A) begin
          st_nxt = (st_r == S_CLEAR) ? S_WAIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          x_nxt      = in_pos_x;
          w_nxt      = in_rect_width;
          ys_nxt     = in_pos_y[2:0];
          es_nxt     = e_sum[2:0];
          h3_nxt     = in_rect_height[2:0];
          erase_nxt  = in_erase;
          rd_idx_nxt = in_read_index;
          p_nxt      = pfde_pkg::PAGE_W'(in_pos_y >>> 3);
          pfirst_nxt = pfde_pkg::PAGE_W'(in_pos_y >>> 3);
          plast_nxt  = pfde_pkg::PAGE_W'(e_sum >>> 3);
          c_nxt      = 8'd0;
          sweep_nxt  = '0;
          unique case (in_mode)
            pfde_pkg::MODE_CLEAR: st_nxt = S_CLEAR;
            pfde_pkg::MODE_PIXEL: st_nxt = S_PIX;
            pfde_pkg::MODE_RECT:  st_nxt = S_RECT;
            pfde_pkg::MODE_READ:  st_nxt = S_READ;
            default:              st_nxt = S_IDLE;
          endcase
        end
      end
      S_PIX: begin
        e_valid  = 1'b1;
        e_ok     = in_range;
        e_wr     = in_range;
        e_status = !in_range;
        e_mask   = 8'd1 << ys_r;
        e_last   = 1'b1;
        st_nxt   = S_WAIT;
      end
      S_RECT: begin
        e_valid = 1'b1;
        e_ok    = in_range;
        e_wr    = in_range && (w_r != 8'd0);
        e_last  = col_end && (p_r == plast_r);
        if (e_last) begin
          st_nxt = S_WAIT;
        end else if (col_end) begin
          c_nxt = 8'd0;
          p_nxt = p_r + pfde_pkg::page_t'(1);
        end else begin
          c_nxt = c_r + 8'd1;
        end
      end
      S_READ: begin
        e_valid = 1'b1;
        e_ok    = rd_wide < RW'(STORE_BYTES);
        e_rd    = 1'b1;
        e_addr  = rd_wide[AW-1:0];
        e_last  = 1'b1;
        st_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (r_valid_r && r_last_r) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // modify stage with forwarding of the last write
  assign cur    = (lw_valid_r && (lw_addr_r == r_addr_r)) ? lw_data_r : rdata_r;
  assign w_data = r_erase_r ? (cur & ~r_mask_r) : (cur | r_mask_r);
  assign w_en   = r_valid_r && r_wr_r;

  always_ff @(posedge clk) begin
    if (e_valid && e_ok) begin
      rdata_r <= mem[e_addr];
    end
    if (w_en) begin
      mem[r_addr_r] <= w_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_INIT;
      sweep_r      <= '0;
      r_valid_r    <= 1'b0;
      r_last_r     <= 1'b0;
      lw_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      sweep_r      <= sweep_nxt;
      r_valid_r    <= e_valid;
      r_last_r     <= e_valid && e_last;
      out_strobe_r <= r_valid_r && r_last_r;
      if (w_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r             <= p_nxt;
    pfirst_r        <= pfirst_nxt;
    plast_r         <= plast_nxt;
    c_r             <= c_nxt;
    x_r             <= x_nxt;
    w_r             <= w_nxt;
    ys_r            <= ys_nxt;
    es_r            <= es_nxt;
    h3_r            <= h3_nxt;
    erase_r         <= erase_nxt;
    rd_idx_r        <= rd_idx_nxt;
    r_ok_r          <= e_ok;
    r_wr_r          <= e_wr;
    r_rd_r          <= e_rd;
    r_erase_r       <= e_erase;
    r_status_r      <= e_status;
    r_addr_r        <= e_addr;
    r_mask_r        <= e_mask;
    out_status_r    <= r_status_r;
    out_read_byte_r <= (r_rd_r && r_ok_r) ? cur : 8'd0;
    if (w_en) begin
      lw_addr_r <= r_addr_r;
      lw_data_r <= w_data;
    end
  end

  `PFDE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted transaction")
  `PFDE_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result shown while still busy")
  `PFDE_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "results back to back")
  `PFDE_ASSERT_NOW(a_last_in_wait, r_valid_r && r_last_r, st_r == S_WAIT,
                   "final byte outside wait state")

endmodule

`default_nettype wire

// ----- verif/page_framebuffer_draw_engine_core_tb.sv -----
`default_nettype none

module page_framebuffer_draw_engine_core_tb;

  localparam int COLUMNS     = 128;
  localparam int STORE_BYTES = 1024;

  typedef struct {
    logic [1:0]        mode;
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic [7:0]        w;
    logic [6:0]        h;
    logic              erase;
    logic [9:0]        ridx;
  } draw_cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] rbyte;
  } draw_ack_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_mode = pfde_pkg::MODE_CLEAR;
  logic signed [8:0]      in_pos_x = '0;
  logic signed [7:0]      in_pos_y = '0;
  logic [7:0]             in_rect_width = '0;
  logic [6:0]             in_rect_height = '0;
  logic                   in_erase = 1'b0;
  logic [9:0]             in_read_index = '0;
  logic                   out_strobe;
  logic                   out_status;
  logic [7:0]             out_read_byte;

  page_framebuffer_draw_engine_core #(
    .COLUMNS(COLUMNS),
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height),
    .in_erase(in_erase),
    .in_read_index(in_read_index),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_read_byte(out_read_byte)
  );

  always #1 clk = ~clk;

  logic [7:0] pixels [0:STORE_BYTES-1];
  draw_cmd_t  cmd_queue[$];
  draw_ack_t  ack_fifo[$];
  draw_cmd_t  on_bus;
  draw_ack_t  new_ack;
  draw_ack_t  want;
  int         n_taken = 0;
  int         n_checked = 0;
  int         n_bad = 0;
  int         n_offstore = 0;
  int         n_mode [4] = '{0, 0, 0, 0};
  bit         calm;

  task automatic report(input string what);
    if (n_bad < 40) $display("mismatch at result %0d: %s", n_checked, what);
    n_bad++;
  endtask

  task automatic stamp_byte(input int idx, input logic [7:0] mask, input logic erase);
    if (idx >= 0 && idx < STORE_BYTES)
      pixels[idx] = erase ? (pixels[idx] & ~mask) : (pixels[idx] | mask);
  endtask

  task automatic paint_columns(input int page, input int xi, input int w,
                               input logic [7:0] mask, input logic erase);
    for (int col = 0; col < w; col++)
      stamp_byte(page * COLUMNS + xi + col, mask, erase);
  endtask

  task automatic draw_into_frame(input draw_cmd_t c, output draw_ack_t r);
    int         xi, yi, hi, wi, e, top, bot, idx;
    logic [2:0] ys, es;
    logic [7:0] mask;
    xi = int'(c.x);
    yi = int'(c.y);
    hi = int'(c.h);
    wi = int'(c.w);
    r.status = 1'b0;
    r.rbyte = 8'h00;
    case (c.mode)
      pfde_pkg::MODE_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) pixels[i] = 8'h00;
      end
      pfde_pkg::MODE_PIXEL: begin
        idx = (yi >>> 3) * COLUMNS + xi;
        if (idx < 0 || idx >= STORE_BYTES) r.status = 1'b1;
        else stamp_byte(idx, 8'h01 << yi[2:0], c.erase);
      end
      pfde_pkg::MODE_RECT: begin
        e = yi + hi;
        top = yi >>> 3;
        bot = e >>> 3;
        ys = yi[2:0];
        es = e[2:0];
        if (top == bot) begin
          mask = ((8'h01 << hi[2:0]) - 8'h01) << ys;
          paint_columns(top, xi, wi, mask, c.erase);
        end else begin
          for (int p = top; p <= bot; p++) begin
            if (p == top) mask = 8'hff << ys;
            else if (p == bot) mask = (8'h01 << es) - 8'h01;
            else mask = 8'hff;
            paint_columns(p, xi, wi, mask, c.erase);
          end
        end
      end
      default: begin
        if (c.ridx < STORE_BYTES) r.rbyte = pixels[c.ridx];
      end
    endcase
  endtask

  task automatic push_cmd(input logic [1:0] mode, input int x, input int y, input int w,
                          input int h, input logic erase, input int ridx);
    draw_cmd_t c;
    c.mode = mode;
    c.x = 9'(x);
    c.y = 8'(y);
    c.w = 8'(w);
    c.h = 7'(h);
    c.erase = erase;
    c.ridx = 10'(ridx);
    cmd_queue.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        draw_into_frame(on_bus, new_ack);
        ack_fifo.push_back(new_ack);
        n_mode[on_bus.mode]++;
        if (new_ack.status) n_offstore++;
        n_taken++;
      end
      if (!(start && busy)) begin
        calm = (n_taken >= 250 && n_taken < 370);
        if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          on_bus = cmd_queue.pop_front();
          start <= 1'b1;
          in_mode <= on_bus.mode;
          in_pos_x <= on_bus.x;
          in_pos_y <= on_bus.y;
          in_rect_width <= on_bus.w;
          in_rect_height <= on_bus.h;
          in_erase <= on_bus.erase;
          in_read_index <= on_bus.ridx;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (ack_fifo.size() == 0) begin
        report("result with no transaction waiting");
      end else begin
        want = ack_fifo.pop_front();
        if (out_status !== want.status)
          report($sformatf("status %b, expected %b", out_status, want.status));
        if (out_read_byte !== want.rbyte)
          report($sformatf("read_byte %h, expected %h", out_read_byte, want.rbyte));
      end
      n_checked++;
    end
  end

  initial begin
    #30000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    draw_cmd_t c;
    int        roll, hot, xi, yi, total;
    bit        noisy;

    // store starts out cleared
    for (int i = 0; i < STORE_BYTES; i++) pixels[i] = 8'h00;

    // empty store, corner pixels, off-store pixels, column run-on into next page
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_PIXEL, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_PIXEL, 127, 63, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 1023);
    push_cmd(pfde_pkg::MODE_PIXEL, -1, 0, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_PIXEL, 0, 64, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_PIXEL, -256, -128, 255, 127, 1'b1, 1023);
    push_cmd(pfde_pkg::MODE_PIXEL, 255, 127, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_PIXEL, 200, 5, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 200);
    push_cmd(pfde_pkg::MODE_PIXEL, 0, 0, 0, 0, 1'b1, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 0);
    // rectangles: single page, zero height, negative origin, page-aligned end, full screen
    push_cmd(pfde_pkg::MODE_RECT, 10, 2, 5, 3, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 12);
    push_cmd(pfde_pkg::MODE_RECT, 20, 9, 10, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_RECT, -5, -3, 20, 30, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 386);
    push_cmd(pfde_pkg::MODE_RECT, 40, 8, 4, 16, 1'b1, 0);
    push_cmd(pfde_pkg::MODE_RECT, 0, 0, 128, 64, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_RECT, -128, -64, 255, 127, 1'b1, 0);
    push_cmd(pfde_pkg::MODE_RECT, 255, 127, 255, 127, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 700);
    push_cmd(pfde_pkg::MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0);
    push_cmd(pfde_pkg::MODE_READ, 0, 0, 0, 0, 1'b0, 1023);

    hot = 0;
    for (int n = 0; n < 558; n++) begin
      c.x = 9'($urandom);
      c.y = 8'($urandom);
      c.w = 8'($urandom);
      c.h = 7'($urandom);
      c.erase = 1'($urandom);
      c.ridx = 10'($urandom);
      roll = int'($urandom_range(99));
      noisy = ($urandom_range(99) < 15);
      if (roll < 3) begin
        c.mode = pfde_pkg::MODE_CLEAR;
      end else if (roll < 68) begin
        c.mode = (roll < 38) ? pfde_pkg::MODE_PIXEL : pfde_pkg::MODE_RECT;
        if (!noisy) begin
          c.x = 9'($urandom_range(143) - 8);
          c.y = 8'($urandom_range(79) - 8);
        end
        if (c.mode == pfde_pkg::MODE_RECT && $urandom_range(9) != 0) begin
          c.w = 8'($urandom_range(20));
          c.h = 7'($urandom_range(24));
        end
        c.erase = ($urandom_range(3) == 0);
        xi = int'(c.x);
        yi = int'(c.y);
        hot = ((yi >>> 3) * COLUMNS + xi) & 1023;
      end else begin
        c.mode = pfde_pkg::MODE_READ;
        if ($urandom_range(1)) c.ridx = 10'(hot + int'($urandom_range(2)));
      end
      cmd_queue.push_back(c);
    end
    total = cmd_queue.size();

    while (n_checked < total) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d clears, %0d pixel writes (%0d off store), %0d rectangles, %0d reads",
             n_mode[pfde_pkg::MODE_CLEAR], n_mode[pfde_pkg::MODE_PIXEL], n_offstore,
             n_mode[pfde_pkg::MODE_RECT], n_mode[pfde_pkg::MODE_READ]);
    $display("%0d results compared, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

endmodule

`default_nettype wire

// ----- page_framebuffer_draw_engine_core.f -----
+incdir+hw/rtl
hw/rtl/pfde_pkg.sv
hw/rtl/page_framebuffer_draw_engine_core.sv
verif/page_framebuffer_draw_engine_core_tb.sv
